// File: hdl/rv32i_execute_unit_defines.svh
// assertion macros used by the checker file
`ifndef RV32I_EXECUTE_UNIT_DEFINES_SVH
`define RV32I_EXECUTE_UNIT_DEFINES_SVH

// condition in the same cycle implies consequence
`define RV_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rv32ex check failed");

// condition implies consequence in the next cycle
`define RV_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rv32ex check failed");

`endif

// File: hdl/rv32ex_pkg.sv
// types, codes and constants of the rv32i execute unit
`timescale 1ns / 1ps
`default_nettype none
package rv32ex_pkg;

    localparam int unsigned XLEN            = 32;
    localparam int unsigned RF_DEPTH        = 32;
    localparam int unsigned CSR_ENTRIES_DEF = 64;
    localparam int unsigned CSR_ADDR_W      = 12;
    localparam int unsigned RECIP_SHIFT     = 24;
    localparam int unsigned IN_TDATA_W      = 136;
    localparam int unsigned OUT_TDATA_W     = 144;

    // dense instruction codes
    typedef enum logic [5:0] {
        OP_LUI    = 6'd0,  OP_AUIPC  = 6'd1,  OP_JAL    = 6'd2,  OP_JALR   = 6'd3,
        OP_BEQ    = 6'd4,  OP_BNE    = 6'd5,  OP_BLT    = 6'd6,  OP_BGE    = 6'd7,
        OP_BLTU   = 6'd8,  OP_BGEU   = 6'd9,  OP_LB     = 6'd10, OP_LH     = 6'd11,
        OP_LW     = 6'd12, OP_LBU    = 6'd13, OP_LHU    = 6'd14, OP_SB     = 6'd15,
        OP_SH     = 6'd16, OP_SW     = 6'd17, OP_ADDI   = 6'd18, OP_SLTI   = 6'd19,
        OP_SLTIU  = 6'd20, OP_XORI   = 6'd21, OP_ORI    = 6'd22, OP_ANDI   = 6'd23,
        OP_SLLI   = 6'd24, OP_SRLI   = 6'd25, OP_SRAI   = 6'd26, OP_ADD    = 6'd27,
        OP_SUB    = 6'd28, OP_SLL    = 6'd29, OP_SLT    = 6'd30, OP_SLTU   = 6'd31,
        OP_XOR    = 6'd32, OP_SRL    = 6'd33, OP_SRA    = 6'd34, OP_OR     = 6'd35,
        OP_AND    = 6'd36, OP_CSRRW  = 6'd37, OP_CSRRS  = 6'd38, OP_CSRRC  = 6'd39,
        OP_CSRRWI = 6'd40, OP_CSRRSI = 6'd41, OP_CSRRCI = 6'd42
    } t_op;

    typedef enum logic [1:0] {
        MEM_NONE  = 2'd0,
        MEM_READ  = 2'd1,
        MEM_WRITE = 2'd2
    } t_mem_req;

    typedef enum logic [1:0] {
        SZ_BYTE = 2'd0,
        SZ_HALF = 2'd1,
        SZ_WORD = 2'd2
    } t_mem_size;

    typedef enum logic [2:0] {
        LK_NONE = 3'd0,
        LK_LB   = 3'd1,
        LK_LH   = 3'd2,
        LK_LW   = 3'd3,
        LK_LBU  = 3'd4,
        LK_LHU  = 3'd5
    } t_load_kind;

    // input beat, last field (op) in the low bits
    typedef struct packed {
        logic [6:0]            pad;
        logic [XLEN-1:0]       load_data;
        logic [XLEN-1:0]       pc_value;
        logic [CSR_ADDR_W-1:0] csr_address;
        logic signed [XLEN-1:0] immediate;
        logic [4:0]            src2_reg;
        logic [4:0]            src1_reg;
        logic [4:0]            dest_reg;
        t_op                   op;
    } t_in_beat;

    // result beat, last field (next_pc) in the low bits
    typedef struct packed {
        logic [4:0]      pad;
        logic [XLEN-1:0] mem_write_data;
        t_mem_size       mem_size;
        logic [XLEN-1:0] mem_address;
        t_mem_req        mem_request;
        logic [XLEN-1:0] wb_value;
        logic [4:0]      wb_reg;
        logic            wb_valid;
        logic            redirect;
        logic [XLEN-1:0] next_pc;
    } t_out_beat;

    // item as carried down the pipe
    typedef struct packed {
        logic            action;
        t_op             op;
        logic [4:0]      rd;
        logic [4:0]      rs1;
        logic [4:0]      rs2;
        logic [XLEN-1:0] imm;
        logic [XLEN-1:0] pc;
        logic [XLEN-1:0] ld;
    } t_item;

endpackage
`default_nettype wire

// File: hdl/rv32i_execute_unit.sv
// rv32i execute unit: register file, csr store and one-pass execute pipe
// path: an accepted beat passes the stage 1, stage 2 and result registers
// throughput: one beat per cycle when not stalled; register file and csr reads are
//   issued one stage ahead from registered rams and bypassed from the last write
// reset: synchronous, active low; afterwards a clearing pass over max(CSR_ENTRIES, 32)
//   addresses zeroes both stores, input tready stays low during it
`timescale 1ns / 1ps
`default_nettype none
module rv32i_execute_unit
    import rv32ex_pkg::*;
#(
    parameter int unsigned CSR_ENTRIES = CSR_ENTRIES_DEF
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_s_tvalid,
    output logic                        o_s_tready,
    // op, dest_reg, src1_reg, src2_reg, immediate, csr_address, pc_value, load_data
    input  wire logic [IN_TDATA_W-1:0]  i_s_tdata,
    // action
    input  wire logic                   i_s_tuser,
    output logic                        o_m_tvalid,
    input  wire logic                   i_m_tready,
    // next_pc, redirect, wb_valid, wb_reg, wb_value, mem_request, mem_address,
    // mem_size, mem_write_data
    output logic [OUT_TDATA_W-1:0]      o_m_tdata
);

    localparam int unsigned IDX_W  = (CSR_ENTRIES > 1) ? $clog2(CSR_ENTRIES) : 1;
    localparam int unsigned CLR_N  = (CSR_ENTRIES > RF_DEPTH) ? CSR_ENTRIES : RF_DEPTH;
    localparam int unsigned CLR_W  = $clog2(CLR_N);
    localparam int unsigned RECIP  = ((2 ** RECIP_SHIFT) + CSR_ENTRIES - 1) / CSR_ENTRIES;
    localparam int unsigned PROD_W = CSR_ADDR_W + RECIP_SHIFT + 1;
    localparam int unsigned QN_W   = 2 * CSR_ADDR_W + 1;

    t_in_beat in_beat;
    assign in_beat = t_in_beat'(i_s_tdata);

    // clearing pass after reset
    logic             r_clr_busy;
    logic [CLR_W-1:0] r_clr_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_cnt  <= '0;
        end else if (r_clr_busy) begin
            r_clr_cnt <= r_clr_cnt + 1'b1;
            if (32'(r_clr_cnt) == CLR_N - 1) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    // pipe control
    logic r_s1_v, r_s2_v, r_out_v;
    logic out_free, s2_adv, s2_free, s1_adv, s1_free, s_acc;

    assign out_free   = !r_out_v || i_m_tready;
    assign s2_adv     = r_s2_v && out_free;
    assign s2_free    = !r_s2_v || s2_adv;
    assign s1_adv     = r_s1_v && s2_free;
    assign s1_free    = !r_s1_v || s1_adv;
    assign o_s_tready = s1_free && !r_clr_busy;
    assign s_acc      = i_s_tvalid && o_s_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v  <= 1'b0;
            r_s2_v  <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            if (s_acc) begin
                r_s1_v <= 1'b1;
            end else if (s1_adv) begin
                r_s1_v <= 1'b0;
            end
            if (s1_adv) begin
                r_s2_v <= 1'b1;
            end else if (s2_adv) begin
                r_s2_v <= 1'b0;
            end
            if (s2_adv) begin
                r_out_v <= 1'b1;
            end else if (i_m_tready) begin
                r_out_v <= 1'b0;
            end
        end
    end

    // stage 1: input register and csr quotient by reciprocal
    t_item                 r_s1;
    logic [CSR_ADDR_W-1:0] r_s1_csr;
    logic [CSR_ADDR_W-1:0] r_s1_q;
    logic [PROD_W-1:0]     n_prod;

    assign n_prod = PROD_W'(in_beat.csr_address) * PROD_W'(RECIP);

    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r_s1.action <= i_s_tuser;
            r_s1.op     <= in_beat.op;
            r_s1.rd     <= in_beat.dest_reg;
            r_s1.rs1    <= in_beat.src1_reg;
            r_s1.rs2    <= in_beat.src2_reg;
            r_s1.imm    <= in_beat.immediate;
            r_s1.pc     <= in_beat.pc_value;
            r_s1.ld     <= in_beat.load_data;
            r_s1_csr    <= in_beat.csr_address;
            r_s1_q      <= CSR_ADDR_W'(n_prod >> RECIP_SHIFT);
        end
    end

    // csr index is the remainder after the exact quotient
    logic [QN_W-1:0]       s1_qn;
    logic [CSR_ADDR_W-1:0] s1_rem;
    logic [IDX_W-1:0]      s1_cidx;

    assign s1_qn   = QN_W'(r_s1_q) * QN_W'(CSR_ENTRIES);
    assign s1_rem  = r_s1_csr - s1_qn[CSR_ADDR_W-1:0];
    assign s1_cidx = s1_rem[IDX_W-1:0];

    // stage 2 register
    t_item            r_s2;
    logic [IDX_W-1:0] r_s2_cidx;

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_s2      <= r_s1;
            r_s2_cidx <= s1_cidx;
        end
    end

    // store write ports, shared with the clearing pass
    logic             wb_en;
    logic [4:0]       wb_reg;
    logic [XLEN-1:0]  wb_val;
    logic             csr_we;
    logic [XLEN-1:0]  csr_wval;
    logic             rf_we;
    logic [4:0]       rf_waddr;
    logic [XLEN-1:0]  rf_wdata;
    logic             cs_we;
    logic [IDX_W-1:0] cs_waddr;
    logic [XLEN-1:0]  cs_wdata;
    logic [XLEN-1:0]  rf1_rdata, rf2_rdata, cs_rdata;

    always_comb begin
        if (r_clr_busy) begin
            rf_we    = (32'(r_clr_cnt) < RF_DEPTH);
            rf_waddr = r_clr_cnt[4:0];
            rf_wdata = '0;
            cs_we    = (32'(r_clr_cnt) < CSR_ENTRIES);
            cs_waddr = IDX_W'(r_clr_cnt);
            cs_wdata = '0;
        end else begin
            rf_we    = s2_adv && wb_en;
            rf_waddr = wb_reg;
            rf_wdata = wb_val;
            cs_we    = s2_adv && csr_we;
            cs_waddr = r_s2_cidx;
            cs_wdata = csr_wval;
        end
    end

    rv32ex_ram #(.WIDTH(XLEN), .DEPTH(RF_DEPTH), .AW(5)) u_rf_a (
        .i_clk   (i_clk),
        .i_we    (rf_we),
        .i_waddr (rf_waddr),
        .i_wdata (rf_wdata),
        .i_re    (s1_adv),
        .i_raddr (r_s1.rs1),
        .o_rdata (rf1_rdata)
    );

    rv32ex_ram #(.WIDTH(XLEN), .DEPTH(RF_DEPTH), .AW(5)) u_rf_b (
        .i_clk   (i_clk),
        .i_we    (rf_we),
        .i_waddr (rf_waddr),
        .i_wdata (rf_wdata),
        .i_re    (s1_adv),
        .i_raddr (r_s1.rs2),
        .o_rdata (rf2_rdata)
    );

    rv32ex_ram #(.WIDTH(XLEN), .DEPTH(CSR_ENTRIES), .AW(IDX_W)) u_csr (
        .i_clk   (i_clk),
        .i_we    (cs_we),
        .i_waddr (cs_waddr),
        .i_wdata (cs_wdata),
        .i_re    (s1_adv),
        .i_raddr (s1_cidx),
        .o_rdata (cs_rdata)
    );

    // bypass of the last write, which the ram read may have missed
    logic             r_fwd_v;
    logic [4:0]       r_fwd_reg;
    logic [XLEN-1:0]  r_fwd_val;
    logic             r_cfwd_v;
    logic [IDX_W-1:0] r_cfwd_idx;
    logic [XLEN-1:0]  r_cfwd_val;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd_v  <= 1'b0;
            r_cfwd_v <= 1'b0;
        end else begin
            if (rf_we && !r_clr_busy) begin
                r_fwd_v   <= 1'b1;
                r_fwd_reg <= rf_waddr;
                r_fwd_val <= rf_wdata;
            end
            if (cs_we && !r_clr_busy) begin
                r_cfwd_v   <= 1'b1;
                r_cfwd_idx <= cs_waddr;
                r_cfwd_val <= cs_wdata;
            end
        end
    end

    // pending load
    logic [4:0] r_pend_reg;
    t_load_kind r_pend_kind;
    logic       pend_set, pend_clr;
    t_load_kind pend_kind_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_reg  <= '0;
            r_pend_kind <= LK_NONE;
        end else if (s2_adv) begin
            if (pend_set) begin
                r_pend_reg  <= r_s2.rd;
                r_pend_kind <= pend_kind_n;
            end else if (pend_clr) begin
                r_pend_kind <= LK_NONE;
            end
        end
    end

    // stage 2: execute
    logic [XLEN-1:0] a, b, c, npc, sum_ai, zimm;
    logic            taken, is_branch;
    logic [4:0]      rd_t;
    logic [XLEN-1:0] val_t;
    logic            val_en;
    t_out_beat       res;

    assign a      = (r_fwd_v && r_fwd_reg == r_s2.rs1 && r_s2.rs1 != 5'd0) ? r_fwd_val
                                                                           : rf1_rdata;
    assign b      = (r_fwd_v && r_fwd_reg == r_s2.rs2 && r_s2.rs2 != 5'd0) ? r_fwd_val
                                                                           : rf2_rdata;
    assign c      = (r_cfwd_v && r_cfwd_idx == r_s2_cidx) ? r_cfwd_val : cs_rdata;
    assign sum_ai = a + r_s2.imm;
    assign zimm   = XLEN'(r_s2.rs2);

    always_comb begin
        res         = '0;
        npc         = r_s2.pc + 32'd4;
        taken       = 1'b0;
        is_branch   = 1'b0;
        rd_t        = r_s2.rd;
        val_t       = '0;
        val_en      = 1'b0;
        csr_we      = 1'b0;
        csr_wval    = c;
        pend_set    = 1'b0;
        pend_clr    = 1'b0;
        pend_kind_n = LK_NONE;
        if (r_s2.action) begin
            // returned load data
            rd_t = r_pend_reg;
            pend_clr = (r_pend_kind != LK_NONE);
            val_en = pend_clr;
            unique case (r_pend_kind)
                LK_LB:   val_t = {{24{r_s2.ld[7]}}, r_s2.ld[7:0]};
                LK_LH:   val_t = {{16{r_s2.ld[15]}}, r_s2.ld[15:0]};
                LK_LW:   val_t = r_s2.ld;
                LK_LBU:  val_t = {24'd0, r_s2.ld[7:0]};
                LK_LHU:  val_t = {16'd0, r_s2.ld[15:0]};
                default: val_t = '0;
            endcase
            npc = '0;
        end else begin
            unique case (r_s2.op)
                OP_LUI:   begin val_en = 1'b1; val_t = r_s2.imm; end
                OP_AUIPC: begin val_en = 1'b1; val_t = r_s2.pc + r_s2.imm; end
                OP_JAL: begin
                    npc = r_s2.pc + r_s2.imm; taken = 1'b1;
                    val_en = 1'b1; val_t = r_s2.pc + 32'd4;
                end
                OP_JALR: begin
                    npc = {sum_ai[XLEN-1:1], 1'b0}; taken = 1'b1;
                    val_en = 1'b1; val_t = r_s2.pc + 32'd4;
                end
                OP_BEQ:  begin is_branch = 1'b1; taken = (a == b); end
                OP_BNE:  begin is_branch = 1'b1; taken = (a != b); end
                OP_BLT:  begin is_branch = 1'b1; taken = ($signed(a) < $signed(b)); end
                OP_BGE:  begin is_branch = 1'b1; taken = !($signed(a) < $signed(b)); end
                OP_BLTU: begin is_branch = 1'b1; taken = (a < b); end
                OP_BGEU: begin is_branch = 1'b1; taken = (a >= b); end
                OP_LB, OP_LH, OP_LW, OP_LBU, OP_LHU: begin
                    res.mem_request = MEM_READ;
                    res.mem_address = sum_ai;
                    pend_set = 1'b1;
                    unique case (r_s2.op)
                        OP_LB:   begin res.mem_size = SZ_BYTE; pend_kind_n = LK_LB;  end
                        OP_LH:   begin res.mem_size = SZ_HALF; pend_kind_n = LK_LH;  end
                        OP_LW:   begin res.mem_size = SZ_WORD; pend_kind_n = LK_LW;  end
                        OP_LBU:  begin res.mem_size = SZ_BYTE; pend_kind_n = LK_LBU; end
                        default: begin res.mem_size = SZ_HALF; pend_kind_n = LK_LHU; end
                    endcase
                end
                OP_SB: begin
                    res.mem_request = MEM_WRITE; res.mem_address = sum_ai;
                    res.mem_size = SZ_BYTE; res.mem_write_data = {24'd0, b[7:0]};
                end
                OP_SH: begin
                    res.mem_request = MEM_WRITE; res.mem_address = sum_ai;
                    res.mem_size = SZ_HALF; res.mem_write_data = {16'd0, b[15:0]};
                end
                OP_SW: begin
                    res.mem_request = MEM_WRITE; res.mem_address = sum_ai;
                    res.mem_size = SZ_WORD; res.mem_write_data = b;
                end
                OP_ADDI:  begin val_en = 1'b1; val_t = sum_ai; end
                OP_SLTI:  begin
                    val_en = 1'b1;
                    val_t = XLEN'($signed(a) < $signed(r_s2.imm));
                end
                OP_SLTIU: begin val_en = 1'b1; val_t = XLEN'(a < r_s2.imm); end
                OP_XORI:  begin val_en = 1'b1; val_t = a ^ r_s2.imm; end
                OP_ORI:   begin val_en = 1'b1; val_t = a | r_s2.imm; end
                OP_ANDI:  begin val_en = 1'b1; val_t = a & r_s2.imm; end
                OP_SLLI:  begin val_en = 1'b1; val_t = a << r_s2.rs2; end
                OP_SRLI:  begin val_en = 1'b1; val_t = a >> r_s2.rs2; end
                OP_SRAI:  begin val_en = 1'b1; val_t = XLEN'($signed(a) >>> r_s2.rs2); end
                OP_ADD:   begin val_en = 1'b1; val_t = a + b; end
                OP_SUB:   begin val_en = 1'b1; val_t = a - b; end
                OP_SLL:   begin val_en = 1'b1; val_t = a << b[4:0]; end
                OP_SLT:   begin val_en = 1'b1; val_t = XLEN'($signed(a) < $signed(b)); end
                OP_SLTU:  begin val_en = 1'b1; val_t = XLEN'(a < b); end
                OP_XOR:   begin val_en = 1'b1; val_t = a ^ b; end
                OP_SRL:   begin val_en = 1'b1; val_t = a >> b[4:0]; end
                OP_SRA:   begin val_en = 1'b1; val_t = XLEN'($signed(a) >>> b[4:0]); end
                OP_OR:    begin val_en = 1'b1; val_t = a | b; end
                OP_AND:   begin val_en = 1'b1; val_t = a & b; end
                OP_CSRRW:  begin val_en = 1'b1; val_t = c; csr_we = 1'b1; csr_wval = a; end
                OP_CSRRS:  begin val_en = 1'b1; val_t = c; csr_we = 1'b1; csr_wval = c | a; end
                OP_CSRRC:  begin val_en = 1'b1; val_t = c; csr_we = 1'b1; csr_wval = c & ~a; end
                OP_CSRRWI: begin val_en = 1'b1; val_t = c; csr_we = 1'b1; csr_wval = zimm; end
                OP_CSRRSI: begin
                    val_en = 1'b1; val_t = c; csr_we = 1'b1; csr_wval = c | zimm;
                end
                OP_CSRRCI: begin
                    val_en = 1'b1; val_t = c; csr_we = 1'b1; csr_wval = c & ~zimm;
                end
                default: ;
            endcase
            if (is_branch && taken) begin
                npc = r_s2.pc + r_s2.imm;
            end
        end
        // writes to x0 are dropped
        wb_en  = val_en && (rd_t != 5'd0);
        wb_reg = rd_t;
        wb_val = val_t;
        res.next_pc  = npc;
        res.redirect = taken;
        res.wb_valid = wb_en;
        res.wb_reg   = wb_en ? rd_t : 5'd0;
        res.wb_value = wb_en ? val_t : '0;
    end

    // result register
    t_out_beat r_out;

    always_ff @(posedge i_clk) begin
        if (s2_adv) begin
            r_out <= res;
        end
    end

    assign o_m_tvalid = r_out_v;
    assign o_m_tdata  = OUT_TDATA_W'(r_out);

endmodule
`default_nettype wire

// File: hdl/rv32ex_ram.sv
// generic single write port ram with registered read
`timescale 1ns / 1ps
`default_nettype none
module rv32ex_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 32,
    parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule
`default_nettype wire

// File: hdl/rv32ex_checker.sv
// port-level checks of the rv32i execute unit and their bind
`timescale 1ns / 1ps
`default_nettype none
`include "rv32i_execute_unit_defines.svh"
module rv32ex_checker
    import rv32ex_pkg::*;
(
    input wire logic                   i_clk,
    input wire logic                   i_rst_n,
    input wire logic                   i_in_ready,
    input wire logic                   i_out_valid,
    input wire logic                   i_out_ready,
    input wire logic [OUT_TDATA_W-1:0] i_out_data
);

    t_out_beat beat;
    assign beat = t_out_beat'(i_out_data);

    // a stalled result beat holds
    `RV_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready,
        i_out_valid && $stable(i_out_data))

    // clearing pass after reset blocks input
    `RV_ASSERT_SAME(a_clr_block, i_clk, i_rst_n, !$past(i_rst_n), !i_in_ready)

    // no write-back means zero write-back fields
    `RV_ASSERT_SAME(a_wb_zero, i_clk, i_rst_n, i_out_valid && !beat.wb_valid,
        beat.wb_reg == 5'd0 && beat.wb_value == '0)

    // control flow change never carries a memory access
    `RV_ASSERT_SAME(a_redir_mem, i_clk, i_rst_n, i_out_valid && beat.redirect,
        beat.mem_request == MEM_NONE && beat.mem_address == '0)

endmodule

bind rv32i_execute_unit rv32ex_checker u_rv32ex_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (o_s_tready),
    .i_out_valid (o_m_tvalid),
    .i_out_ready (i_m_tready),
    .i_out_data  (o_m_tdata)
);
`default_nettype wire

// File: tb/tb_rv32i_execute_unit.sv
// testbench for the rv32i execute unit: instruction stimulus, prediction and result checks
`timescale 1ns / 1ps
`default_nettype none
module tb_rv32i_execute_unit;
    import rv32ex_pkg::*;

    // predicts result beats from accepted instruction beats and checks them in order
    class exec_scoreboard;
        logic [31:0] gpr [32];
        logic [31:0] csr_mem [CSR_ENTRIES_DEF];
        logic [4:0]  load_rd;
        t_load_kind  load_kind;
        t_out_beat   expected_q [$];
        int          errors;

        function new();
            foreach (gpr[i]) gpr[i] = '0;
            foreach (csr_mem[i]) csr_mem[i] = '0;
            load_rd   = '0;
            load_kind = LK_NONE;
            errors    = 0;
        endfunction

        function logic [31:0] gpr_read(logic [4:0] idx);
            return (idx == 5'd0) ? 32'd0 : gpr[idx];
        endfunction

        // register write-back, x0 writes are dropped
        function void write_back(inout t_out_beat r, input logic [4:0] rd,
                                 input logic [31:0] val);
            if (rd == 5'd0) return;
            gpr[rd]    = val;
            r.wb_valid = 1'b1;
            r.wb_reg   = rd;
            r.wb_value = val;
        endfunction

        function void note_input(logic action, t_in_beat b);
            t_out_beat   r;
            logic [31:0] a, bv, imm, old_csr, v;
            int unsigned cidx;
            logic        taken;
            r     = '0;
            taken = 1'b0;
            imm   = b.immediate;
            cidx  = b.csr_address % CSR_ENTRIES_DEF;
            // returned load data
            if (action) begin
                case (load_kind)
                    LK_LB:   v = {{24{b.load_data[7]}}, b.load_data[7:0]};
                    LK_LH:   v = {{16{b.load_data[15]}}, b.load_data[15:0]};
                    LK_LW:   v = b.load_data;
                    LK_LBU:  v = {24'd0, b.load_data[7:0]};
                    LK_LHU:  v = {16'd0, b.load_data[15:0]};
                    default: v = '0;
                endcase
                if (load_kind != LK_NONE) begin
                    load_kind = LK_NONE;
                    write_back(r, load_rd, v);
                end
                expected_q.push_back(r);
                return;
            end
            a         = gpr_read(b.src1_reg);
            bv        = gpr_read(b.src2_reg);
            r.next_pc = b.pc_value + 32'd4;
            old_csr   = csr_mem[cidx];
            case (b.op)
                OP_LUI:   write_back(r, b.dest_reg, imm);
                OP_AUIPC: write_back(r, b.dest_reg, b.pc_value + imm);
                OP_JAL: begin
                    r.next_pc = b.pc_value + imm;
                    taken     = 1'b1;
                    write_back(r, b.dest_reg, b.pc_value + 32'd4);
                end
                OP_JALR: begin
                    r.next_pc = (a + imm) & ~32'd1;
                    taken     = 1'b1;
                    write_back(r, b.dest_reg, b.pc_value + 32'd4);
                end
                OP_BEQ:  taken = (a == bv);
                OP_BNE:  taken = (a != bv);
                OP_BLT:  taken = ($signed(a) < $signed(bv));
                OP_BGE:  taken = ($signed(a) >= $signed(bv));
                OP_BLTU: taken = (a < bv);
                OP_BGEU: taken = (a >= bv);
                OP_LB, OP_LH, OP_LW, OP_LBU, OP_LHU: begin
                    r.mem_request = MEM_READ;
                    r.mem_address = a + imm;
                    r.mem_size    = (b.op == OP_LB || b.op == OP_LBU) ? SZ_BYTE :
                                    (b.op == OP_LH || b.op == OP_LHU) ? SZ_HALF : SZ_WORD;
                    load_rd       = b.dest_reg;
                    load_kind     = t_load_kind'(b.op - OP_LB + 1);
                end
                OP_SB, OP_SH, OP_SW: begin
                    r.mem_request    = MEM_WRITE;
                    r.mem_address    = a + imm;
                    r.mem_size       = (b.op == OP_SB) ? SZ_BYTE :
                                       (b.op == OP_SH) ? SZ_HALF : SZ_WORD;
                    r.mem_write_data = (b.op == OP_SB) ? (bv & 32'hff) :
                                       (b.op == OP_SH) ? (bv & 32'hffff) : bv;
                end
                OP_ADDI:  write_back(r, b.dest_reg, a + imm);
                OP_SLTI:  write_back(r, b.dest_reg, {31'd0, $signed(a) < $signed(imm)});
                OP_SLTIU: write_back(r, b.dest_reg, {31'd0, a < imm});
                OP_XORI:  write_back(r, b.dest_reg, a ^ imm);
                OP_ORI:   write_back(r, b.dest_reg, a | imm);
                OP_ANDI:  write_back(r, b.dest_reg, a & imm);
                OP_SLLI:  write_back(r, b.dest_reg, a << b.src2_reg);
                OP_SRLI:  write_back(r, b.dest_reg, a >> b.src2_reg);
                OP_SRAI:  write_back(r, b.dest_reg, $signed(a) >>> b.src2_reg);
                OP_ADD:   write_back(r, b.dest_reg, a + bv);
                OP_SUB:   write_back(r, b.dest_reg, a - bv);
                OP_SLL:   write_back(r, b.dest_reg, a << bv[4:0]);
                OP_SLT:   write_back(r, b.dest_reg, {31'd0, $signed(a) < $signed(bv)});
                OP_SLTU:  write_back(r, b.dest_reg, {31'd0, a < bv});
                OP_XOR:   write_back(r, b.dest_reg, a ^ bv);
                OP_SRL:   write_back(r, b.dest_reg, a >> bv[4:0]);
                OP_SRA:   write_back(r, b.dest_reg, $signed(a) >>> bv[4:0]);
                OP_OR:    write_back(r, b.dest_reg, a | bv);
                OP_AND:   write_back(r, b.dest_reg, a & bv);
                OP_CSRRW: begin
                    csr_mem[cidx] = a;
                    write_back(r, b.dest_reg, old_csr);
                end
                OP_CSRRS: begin
                    csr_mem[cidx] = old_csr | a;
                    write_back(r, b.dest_reg, old_csr);
                end
                OP_CSRRC: begin
                    csr_mem[cidx] = old_csr & ~a;
                    write_back(r, b.dest_reg, old_csr);
                end
                OP_CSRRWI: begin
                    csr_mem[cidx] = {27'd0, b.src2_reg};
                    write_back(r, b.dest_reg, old_csr);
                end
                OP_CSRRSI: begin
                    csr_mem[cidx] = old_csr | {27'd0, b.src2_reg};
                    write_back(r, b.dest_reg, old_csr);
                end
                OP_CSRRCI: begin
                    csr_mem[cidx] = old_csr & ~{27'd0, b.src2_reg};
                    write_back(r, b.dest_reg, old_csr);
                end
                default: ;
            endcase
            if (taken && b.op >= OP_BEQ && b.op <= OP_BGEU) r.next_pc = b.pc_value + imm;
            r.redirect = taken;
            expected_q.push_back(r);
        endfunction

        function void mismatch(string name, logic [31:0] exp_v, logic [31:0] act_v);
            errors++;
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
        endfunction

        function void check_result(t_out_beat got);
            t_out_beat e;
            if (expected_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected result beat %h", $time, got);
                return;
            end
            e = expected_q.pop_front();
            if (got.next_pc !== e.next_pc) mismatch("next_pc", e.next_pc, got.next_pc);
            if (got.redirect !== e.redirect) mismatch("redirect", e.redirect, got.redirect);
            if (got.wb_valid !== e.wb_valid) mismatch("wb_valid", e.wb_valid, got.wb_valid);
            if (got.wb_reg !== e.wb_reg) mismatch("wb_reg", e.wb_reg, got.wb_reg);
            if (got.wb_value !== e.wb_value) mismatch("wb_value", e.wb_value, got.wb_value);
            if (got.mem_request !== e.mem_request)
                mismatch("mem_request", e.mem_request, got.mem_request);
            if (got.mem_address !== e.mem_address)
                mismatch("mem_address", e.mem_address, got.mem_address);
            if (got.mem_size !== e.mem_size) mismatch("mem_size", e.mem_size, got.mem_size);
            if (got.mem_write_data !== e.mem_write_data)
                mismatch("mem_write_data", e.mem_write_data, got.mem_write_data);
        endfunction
    endclass

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_s_tvalid = 1'b0;
    logic                   o_s_tready;
    logic [IN_TDATA_W-1:0]  i_s_tdata = '0;
    logic                   i_s_tuser = 1'b0;
    logic                   o_m_tvalid;
    logic                   i_m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] o_m_tdata;

    exec_scoreboard exec_sb;
    int             src_idle_pct = 36;
    int             sink_idle_pct = 36;

    rv32i_execute_unit u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    always #4 i_clk = ~i_clk;

    // result side stall and check
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) exec_sb.check_result(t_out_beat'(o_m_tdata));
        i_m_tready <= ($urandom_range(99) >= sink_idle_pct);
    end

    function automatic t_in_beat instr(t_op op, logic [4:0] rd, logic [4:0] rs1,
                                       logic [4:0] rs2, logic [31:0] imm);
        t_in_beat b;
        b             = '0;
        b.op          = op;
        b.dest_reg    = rd;
        b.src1_reg    = rs1;
        b.src2_reg    = rs2;
        b.immediate   = imm;
        b.csr_address = 12'($urandom_range(4095));
        b.pc_value    = $urandom;
        b.load_data   = $urandom;
        return b;
    endfunction

    // one input beat with random gaps before it
    task automatic send_beat(logic action, t_in_beat b);
        while ($urandom_range(99) < src_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= b;
        i_s_tuser  <= action;
        do @(posedge i_clk); while (!o_s_tready);
        exec_sb.note_input(action, b);
    endtask

    task automatic send_load_data(logic [31:0] data);
        t_in_beat b;
        b           = instr(t_op'($urandom_range(63)), 5'($urandom), 5'($urandom),
                            5'($urandom), $urandom);
        b.load_data = data;
        send_beat(1'b1, b);
    endtask

    function automatic logic [31:0] rand_imm();
        case ($urandom_range(5))
            0:       return 32'h8000_0000;
            1:       return 32'h7fff_ffff;
            2:       return 32'hffff_ffff;
            3:       return $urandom_range(16) - 8;
            default: return $urandom;
        endcase
    endfunction

    // mostly real instructions, with loads mostly followed by their data, plus noise
    task automatic random_item();
        t_in_beat b;
        int       pick;
        pick = $urandom_range(99);
        if (pick < 6) begin
            b = instr(t_op'($urandom_range(63, 43)), 5'($urandom), 5'($urandom),
                      5'($urandom), $urandom);
            send_beat(1'b0, b);
        end else if (pick < 12) begin
            send_load_data($urandom);
        end else begin
            b = instr(t_op'($urandom_range(42)), 5'($urandom), 5'($urandom),
                      5'($urandom), rand_imm());
            if (b.op >= OP_BEQ && b.op <= OP_BGEU && $urandom_range(3) == 0)
                b.src2_reg = b.src1_reg;
            send_beat(1'b0, b);
            if (b.op >= OP_LB && b.op <= OP_LHU && $urandom_range(9) < 8)
                send_load_data($urandom);
        end
    endtask

    initial begin
        t_in_beat b;
        exec_sb = new();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: extreme operands, special cases
        send_beat(1'b0, instr(OP_LUI, 5'd1, 5'd0, 5'd0, 32'h8000_0000));
        send_beat(1'b0, instr(OP_LUI, 5'd2, 5'd0, 5'd0, 32'h7fff_ffff));
        send_beat(1'b0, instr(OP_LUI, 5'd3, 5'd0, 5'd0, 32'hffff_ffff));
        send_beat(1'b0, instr(OP_ADDI, 5'd0, 5'd3, 5'd0, 32'h1234));
        send_beat(1'b0, instr(OP_SRA, 5'd4, 5'd1, 5'd3, 32'd0));
        send_beat(1'b0, instr(OP_SRAI, 5'd5, 5'd1, 5'd31, 32'd0));
        send_beat(1'b0, instr(OP_SLT, 5'd6, 5'd1, 5'd2, 32'd0));
        send_beat(1'b0, instr(OP_SLTU, 5'd7, 5'd1, 5'd2, 32'd0));
        send_beat(1'b0, instr(OP_BLT, 5'd0, 5'd1, 5'd2, 32'd4));
        send_beat(1'b0, instr(OP_BGEU, 5'd0, 5'd3, 5'd2, 32'hffff_fff0));
        send_beat(1'b0, instr(OP_JAL, 5'd8, 5'd0, 5'd0, 32'd4));
        send_beat(1'b0, instr(OP_JALR, 5'd9, 5'd3, 5'd0, 32'd0));
        send_beat(1'b0, instr(OP_LB, 5'd10, 5'd1, 5'd0, 32'd3));
        send_load_data(32'h0000_0080);
        send_beat(1'b0, instr(OP_LHU, 5'd11, 5'd2, 5'd0, 32'd1));
        send_load_data(32'hffff_8001);
        send_load_data(32'hdead_beef);
        send_beat(1'b0, instr(OP_LW, 5'd12, 5'd0, 5'd0, 32'd0));
        send_beat(1'b0, instr(OP_LH, 5'd13, 5'd0, 5'd0, 32'd2));
        send_load_data(32'h1234_8765);
        send_beat(1'b0, instr(OP_SB, 5'd0, 5'd2, 5'd3, 32'd0));
        b             = instr(OP_CSRRW, 5'd14, 5'd3, 5'd0, 32'd0);
        b.csr_address = 12'hfff;
        send_beat(1'b0, b);
        b             = instr(OP_CSRRS, 5'd15, 5'd0, 5'd0, 32'd0);
        b.csr_address = 12'h03f;
        send_beat(1'b0, b);
        b             = instr(OP_CSRRCI, 5'd16, 5'd0, 5'd31, 32'd0);
        b.csr_address = 12'h03f;
        send_beat(1'b0, b);
        send_beat(1'b0, instr(t_op'(6'd63), 5'd17, 5'd1, 5'd2, 32'hffff_ffff));

        // random part, with a stretch of back-to-back beats in the middle
        for (int n = 0; n < 1100; n++) begin
            src_idle_pct  = (n >= 500 && n < 700) ? 0 : 36;
            sink_idle_pct = src_idle_pct;
            random_item();
        end
        i_s_tvalid <= 1'b0;

        while (exec_sb.expected_q.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (exec_sb.errors == 0 && exec_sb.expected_q.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    // watchdog
    initial begin
        #5ms;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
`default_nettype wire
